### rtl/dtr_pkg.sv
`default_nettype none

package dtr_pkg;

  localparam int unsigned MAX_TICKS = 255;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned CTL_W  = 3;

  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd2;

  localparam logic [BYTE_W-1:0] CTL_READ_ONES = 8'hF8;

  typedef enum logic [1:0] {
    REG_DIV    = 2'd0,
    REG_COUNT  = 2'd1,
    REG_RELOAD = 2'd2,
    REG_CTL    = 2'd3
  } reg_sel_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // divider bit chosen by control[1:0], gated by the enable bit
  function automatic logic tap_signal(logic [DIV_W-1:0] div, logic [CTL_W-1:0] ctl);
    logic bit_sel;
    unique case (ctl[1:0])
      2'd0: bit_sel = div[9];
      2'd1: bit_sel = div[3];
      2'd2: bit_sel = div[5];
      2'd3: bit_sel = div[7];
    endcase
    return bit_sel & ctl[2];
  endfunction

endpackage

`default_nettype wire

### rtl/dtr_if.sv
`default_nettype none

interface dtr_in_if import dtr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [1:0]          reg_select;
  logic [BYTE_W-1:0]   write_data;
  logic [BYTE_W-1:0]   tick_count;

  modport source (output valid, kind, reg_select, write_data, tick_count, input ready);
  modport sink   (input valid, kind, reg_select, write_data, tick_count, output ready);
endinterface

interface dtr_out_if import dtr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic                timer_interrupt;

  modport source (output valid, read_data, timer_interrupt, input ready);
  modport sink   (input valid, read_data, timer_interrupt, output ready);
endinterface

`default_nettype wire

### rtl/divider_timer_with_reload.sv
// channel  direction  payload
// in_if    sink       kind, reg_select, write_data, tick_count
// out_if   source     read_data, timer_interrupt
//
// an advance beat applies min(tick_count, MaxTicks) ticks in ST_EXEC, one tick per
// cycle through the shared divider increment and edge sampler
// reads and writes finish in ST_EXEC once the output register is free; their result is then registered
// in_if.ready is high only while no beat is being executed
// a result waits in the output register; the next beat may be accepted meanwhile
// reset clears all timer registers and the handshake state
`default_nettype none

module divider_timer_with_reload import dtr_pkg::*; #(
  parameter int unsigned MaxTicks = MAX_TICKS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtr_in_if.sink    in_if,
  dtr_out_if.source out_if
);

  localparam int unsigned CntW = $clog2(MaxTicks + 1);

  state_e              state_q, state_d;
  logic [DIV_W-1:0]    div_q, div_d;
  logic [BYTE_W-1:0]   tima_q, tima_d;
  logic [BYTE_W-1:0]   tma_q, tma_d;
  logic [CTL_W-1:0]    ctl_q, ctl_d;
  logic                last_q, last_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                irq_q, irq_d;
  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  reg_sel_e            sel_q, sel_d;
  logic [BYTE_W-1:0]   data_q, data_d;
  logic [BYTE_W-1:0]   rd_q, rd_d;
  logic                oirq_q, oirq_d;

  logic                in_acc;
  logic                ticking;
  logic                finish;

  // shared sampler
  logic                smp_en;
  logic [DIV_W-1:0]    smp_div;
  logic [CTL_W-1:0]    smp_ctl;
  logic                smp_sig;
  logic                smp_fall;
  logic [BYTE_W-1:0]   smp_inc;
  logic [BYTE_W-1:0]   smp_tima;
  logic                smp_ovf;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ticking     = (kind_q == KIND_ADVANCE) && (cnt_q != '0);
  assign finish      = (state_q == ST_EXEC) && !ticking && (!out_valid_q || out_if.ready);

  assign smp_sig  = tap_signal(smp_div, smp_ctl);
  assign smp_fall = last_q && !smp_sig;
  assign smp_inc  = tima_q + 8'd1;
  assign smp_tima = (smp_inc == '0) ? tma_q : smp_inc;
  assign smp_ovf  = smp_en && smp_fall && (smp_inc == '0);

  assign out_if.valid           = out_valid_q;
  assign out_if.read_data       = rd_q;
  assign out_if.timer_interrupt = oirq_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (finish) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    div_d       = div_q;
    tima_d      = tima_q;
    tma_d       = tma_q;
    ctl_d       = ctl_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    irq_d       = irq_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    sel_d       = sel_q;
    data_d      = data_q;
    rd_d        = rd_q;
    oirq_d      = oirq_q;
    smp_en      = 1'b0;
    smp_div     = div_q;
    smp_ctl     = ctl_q;

    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;

    if (in_acc) begin
      kind_d = in_if.kind;
      sel_d  = reg_sel_e'(in_if.reg_select);
      data_d = in_if.write_data;
      irq_d  = 1'b0;
      cnt_d  = (in_if.tick_count > BYTE_W'(MaxTicks)) ? CntW'(MaxTicks)
                                                       : CntW'(in_if.tick_count);
    end

    if (state_q == ST_EXEC && ticking) begin
      div_d   = div_q + 16'd1;
      smp_div = div_d;
      smp_en  = 1'b1;
      cnt_d   = cnt_q - CntW'(1);
      irq_d   = irq_q | smp_ovf;
    end

    if (finish) begin
      out_valid_d = 1'b1;
      rd_d        = '0;
      if (kind_q == KIND_READ) begin
        unique case (sel_q)
          REG_DIV:    rd_d = div_q[DIV_W-1:BYTE_W];
          REG_COUNT:  rd_d = tima_q;
          REG_RELOAD: rd_d = tma_q;
          REG_CTL:    rd_d = CTL_READ_ONES | BYTE_W'(ctl_q);
        endcase
      end else if (kind_q == KIND_WRITE) begin
        unique case (sel_q)
          REG_DIV: begin
            div_d   = '0;
            smp_div = '0;
            smp_en  = 1'b1;
          end
          REG_COUNT:  tima_d = data_q;
          REG_RELOAD: tma_d  = data_q;
          REG_CTL: begin
            ctl_d   = data_q[CTL_W-1:0];
            smp_ctl = data_q[CTL_W-1:0];
            smp_en  = 1'b1;
          end
        endcase
      end
      oirq_d = irq_q | smp_ovf;
    end

    if (smp_en) begin
      last_d = smp_sig;
      if (smp_fall) tima_d = smp_tima;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= '0;
      tima_q      <= '0;
      tma_q       <= '0;
      ctl_q       <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      tima_q      <= tima_d;
      tma_q       <= tma_d;
      ctl_q       <= ctl_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sel_q  <= sel_d;
    data_q <= data_d;
    rd_q   <= rd_d;
    oirq_q <= oirq_d;
  end

endmodule

`default_nettype wire

### rtl/dtr_checker.sv
`default_nettype none

module dtr_checker import dtr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] read_data_i,
  input logic              timer_interrupt_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // beats accepted whose result is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(timer_interrupt_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("ready high right after an accepted beat");

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without accepted beat");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i && out_valid_i)
    else $error("more than one beat in flight behind a waiting result");

  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && timer_interrupt_i |-> read_data_i == '0)
    else $error("interrupt reported with read data");

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .read_data_i       (out_if.read_data),
  .timer_interrupt_i (out_if.timer_interrupt)
);

`default_nettype wire
